>>> hw/rtl/mavt_pkg.sv
// ----------------------------------------------------------------------------
// Multi-turn angle and velocity tracker package
// Shared widths, register reset values, register indexes and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package mavt_pkg;

    // Defaults for the top-level parameters.
    localparam int ANGLE_BITS_DEF = 12;
    localparam int TURN_BITS_DEF  = 20;
    localparam int TIMER_BITS_DEF = 24;

    // Fixed field widths.
    localparam int POS_W  = 32;
    localparam int VEL_W  = 48;
    localparam int THR_W  = 12;
    localparam int RATE_W = 28;
    localparam int INTV_W = 24;

    // Serial multiply and divide.
    localparam int MAG_W       = POS_W;
    localparam int PROD_W      = MAG_W + RATE_W;
    localparam int MUL_DIGIT_W = 2;
    localparam int MUL_STEPS   = RATE_W / MUL_DIGIT_W;
    localparam int DIV_STEPS   = VEL_W;
    localparam int CNT_W       = $clog2(DIV_STEPS);

    // Configuration channel.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;

    localparam logic [THR_W-1:0]  WRAP_THRESHOLD_RST   = 12'd3277;
    localparam logic [RATE_W-1:0] TICK_RATE_HZ_RST     = 28'd170000000;
    localparam logic [INTV_W-1:0] MAX_INTERVAL_RST     = 24'd16777215;
    localparam logic [INTV_W-1:0] DEFAULT_INTERVAL_RST = 24'd170000;
    localparam logic              REVERSE_RST          = 1'b0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WRAP_THRESHOLD   = 3'd0,
        REG_TICK_RATE_HZ     = 3'd1,
        REG_MAX_INTERVAL     = 3'd2,
        REG_DEFAULT_INTERVAL = 3'd3,
        REG_REVERSE          = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [THR_W-1:0]  wrap_threshold;
        logic [RATE_W-1:0] tick_rate_hz;
        logic [INTV_W-1:0] max_interval_ticks;
        logic [INTV_W-1:0] default_interval_ticks;
        logic              reverse_direction;
    } cfg_t;

    typedef struct packed {
        logic start;
        logic take;
    } md_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/mavt_if.sv
// ----------------------------------------------------------------------------
// Multi-turn angle and velocity tracker channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mavt_sample_if #(
    parameter int ANGLE_BITS = mavt_pkg::ANGLE_BITS_DEF,
    parameter int TIMER_BITS = mavt_pkg::TIMER_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [ANGLE_BITS-1:0] enc_angle;
    logic [TIMER_BITS-1:0] timestamp;

    modport source (output valid, output enc_angle, output timestamp, input ready);
    modport sink   (input valid, input enc_angle, input timestamp, output ready);
endinterface

interface mavt_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [mavt_pkg::POS_W-1:0] position;
    logic signed [mavt_pkg::VEL_W-1:0] velocity;
    logic                              interval_substituted;

    modport source (output valid, output position, output velocity,
                    output interval_substituted, input ready);
    modport sink   (input valid, input position, input velocity,
                    input interval_substituted, output ready);
endinterface

interface mavt_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [mavt_pkg::CFG_IDX_W-1:0]      index;
    logic [mavt_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/multiturn_angle_velocity_tracker.sv
// ----------------------------------------------------------------------------
// Multi-turn angle and velocity tracker
// Counts encoder revolutions, reports position in counts and velocity in
// counts per second from a down-counting timer stamp.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Payload
//   sample    in          enc_angle, timestamp
//   result    out         position, velocity, interval_substituted
//   cfg       in          index, data (write only, always ready)
//
// A sample transaction is taken only after the previous one has passed the 14
// radix-4 multiply steps and the 48 one-bit restoring divide steps of the serial
// velocity unit, plus load, setup, overflow check, saturation, hand-off and
// return to idle. An overflowing quotient skips the divide.
// Reset clears the turn count, the previous angle, position and stamp, and
// loads the register defaults. A result waiting on result.ready does not stop
// the next sample from being taken; only a second finished result waits.
`default_nettype none

module multiturn_angle_velocity_tracker #(
    parameter int ANGLE_BITS = mavt_pkg::ANGLE_BITS_DEF,
    parameter int TURN_BITS  = mavt_pkg::TURN_BITS_DEF,
    parameter int TIMER_BITS = mavt_pkg::TIMER_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    mavt_sample_if.sink   sample,
    mavt_result_if.source result,
    mavt_cfg_if.sink      cfg
);

    localparam int DT_W = (TIMER_BITS > mavt_pkg::INTV_W) ? TIMER_BITS : mavt_pkg::INTV_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_TRACK = 3'b010,
        ST_CALC  = 3'b100
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic                       out_valid_reg;
    logic [mavt_pkg::POS_W-1:0] position_reg;
    logic [mavt_pkg::VEL_W-1:0] velocity_reg;
    logic                       subst_reg;

    mavt_pkg::cfg_t             regs;
    mavt_pkg::md_ctrl_t         md_ctrl;
    logic                       sample_fire;
    logic                       take;
    logic                       md_done;
    logic [mavt_pkg::VEL_W-1:0] md_velocity;
    logic [mavt_pkg::POS_W-1:0] trk_position;
    logic [mavt_pkg::POS_W-1:0] trk_dpos;
    logic [DT_W-1:0]            trk_dt;
    logic                       trk_subst;

    mavt_cfg u_cfg (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg),
        .regs (regs)
    );

    mavt_track #(
        .ANGLE_BITS(ANGLE_BITS),
        .TURN_BITS (TURN_BITS),
        .TIMER_BITS(TIMER_BITS),
        .DT_W      (DT_W)
    ) u_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (sample_fire),
        .enc_angle(sample.enc_angle),
        .timestamp(sample.timestamp),
        .cfg      (regs),
        .position (trk_position),
        .dpos     (trk_dpos),
        .dt       (trk_dt),
        .subst    (trk_subst)
    );

    mavt_muldiv #(
        .DT_W(DT_W)
    ) u_muldiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (md_ctrl),
        .dpos    (trk_dpos),
        .dt      (trk_dt),
        .rate    (regs.tick_rate_hz),
        .reverse (regs.reverse_direction),
        .done    (md_done),
        .velocity(md_velocity)
    );

    assign sample.ready  = (state_reg == ST_IDLE);
    assign sample_fire   = sample.valid && sample.ready;
    assign take          = (state_reg == ST_CALC) && md_done && (!out_valid_reg || result.ready);
    assign md_ctrl.start = (state_reg == ST_TRACK);
    assign md_ctrl.take  = take;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_fire)
                begin
                    state_next = ST_TRACK;
                end
            end
            ST_TRACK:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            position_reg <= trk_position;
            velocity_reg <= md_velocity;
            subst_reg    <= trk_subst;
        end
    end

    assign result.valid                = out_valid_reg;
    assign result.position             = position_reg;
    assign result.velocity             = velocity_reg;
    assign result.interval_substituted = subst_reg;

endmodule

`default_nettype wire

>>> hw/rtl/mavt_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the five control registers written over the configuration channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mavt_cfg (
    input  wire logic      clk,
    input  wire logic      rst_n,
    mavt_cfg_if.sink       cfg,
    output mavt_pkg::cfg_t regs
);

    mavt_pkg::cfg_t regs_reg;
    mavt_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (mavt_pkg::cfg_idx_t'(cfg.index))
                mavt_pkg::REG_WRAP_THRESHOLD:
                    regs_next.wrap_threshold = cfg.data[mavt_pkg::THR_W-1:0];
                mavt_pkg::REG_TICK_RATE_HZ:
                    regs_next.tick_rate_hz = cfg.data[mavt_pkg::RATE_W-1:0];
                mavt_pkg::REG_MAX_INTERVAL:
                    regs_next.max_interval_ticks = cfg.data[mavt_pkg::INTV_W-1:0];
                mavt_pkg::REG_DEFAULT_INTERVAL:
                    regs_next.default_interval_ticks = cfg.data[mavt_pkg::INTV_W-1:0];
                mavt_pkg::REG_REVERSE:
                    regs_next.reverse_direction = cfg.data[0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.wrap_threshold         <= mavt_pkg::WRAP_THRESHOLD_RST;
            regs_reg.tick_rate_hz           <= mavt_pkg::TICK_RATE_HZ_RST;
            regs_reg.max_interval_ticks     <= mavt_pkg::MAX_INTERVAL_RST;
            regs_reg.default_interval_ticks <= mavt_pkg::DEFAULT_INTERVAL_RST;
            regs_reg.reverse_direction      <= mavt_pkg::REVERSE_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/mavt_track.sv
// ----------------------------------------------------------------------------
// Turn tracker
// Detects revolution wraps, builds the position and measures the interval.
// ----------------------------------------------------------------------------
`default_nettype none

module mavt_track #(
    parameter int ANGLE_BITS = mavt_pkg::ANGLE_BITS_DEF,
    parameter int TURN_BITS  = mavt_pkg::TURN_BITS_DEF,
    parameter int TIMER_BITS = mavt_pkg::TIMER_BITS_DEF,
    parameter int DT_W       = mavt_pkg::INTV_W
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire logic [ANGLE_BITS-1:0]       enc_angle,
    input  wire logic [TIMER_BITS-1:0]       timestamp,
    input  wire mavt_pkg::cfg_t              cfg,
    output logic [mavt_pkg::POS_W-1:0]       position,
    output logic [mavt_pkg::POS_W-1:0]       dpos,
    output logic [DT_W-1:0]                  dt,
    output logic                             subst
);

    localparam int CMP_W = (ANGLE_BITS > mavt_pkg::THR_W) ? ANGLE_BITS : mavt_pkg::THR_W;

    logic [ANGLE_BITS-1:0]      angle_reg;
    logic [TURN_BITS-1:0]       turn_reg;
    logic [TURN_BITS-1:0]       turn_next;
    logic [mavt_pkg::POS_W-1:0] pos_reg;
    logic [mavt_pkg::POS_W-1:0] pos_next;
    logic [TIMER_BITS-1:0]      ts_reg;
    logic [mavt_pkg::POS_W-1:0] dpos_reg;
    logic [mavt_pkg::POS_W-1:0] dpos_next;
    logic [DT_W-1:0]            dt_reg;
    logic [DT_W-1:0]            dt_next;
    logic                       subst_reg;
    logic                       subst_next;

    logic [ANGLE_BITS-1:0]      jump;
    logic                       jump_up;
    logic [mavt_pkg::POS_W-1:0] turn_ext;
    logic [TIMER_BITS-1:0]      elapsed;
    logic [DT_W-1:0]            dt_sel;

    always_comb
    begin
        if (enc_angle >= angle_reg)
        begin
            jump    = enc_angle - angle_reg;
            jump_up = (jump != '0);
        end
        else
        begin
            jump    = angle_reg - enc_angle;
            jump_up = 1'b0;
        end

        // A large forward jump is a wrap backward through zero, and vice versa.
        turn_next = turn_reg;
        if (CMP_W'(jump) > CMP_W'(cfg.wrap_threshold))
        begin
            turn_next = jump_up ? (turn_reg - 1'b1) : (turn_reg + 1'b1);
        end

        turn_ext  = mavt_pkg::POS_W'($signed(turn_next));
        pos_next  = {turn_ext[mavt_pkg::POS_W-ANGLE_BITS-1:0], enc_angle};
        dpos_next = pos_next - pos_reg;

        elapsed    = ts_reg - timestamp;
        subst_next = (elapsed == '0) || (DT_W'(elapsed) > DT_W'(cfg.max_interval_ticks));
        dt_sel     = subst_next ? DT_W'(cfg.default_interval_ticks) : DT_W'(elapsed);
        dt_next    = (dt_sel == '0) ? DT_W'(1) : dt_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= '0;
            turn_reg  <= '0;
            pos_reg   <= '0;
            ts_reg    <= '0;
        end
        else if (load)
        begin
            angle_reg <= enc_angle;
            turn_reg  <= turn_next;
            pos_reg   <= pos_next;
            ts_reg    <= timestamp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dpos_reg  <= dpos_next;
            dt_reg    <= dt_next;
            subst_reg <= subst_next;
        end
    end

    assign position = pos_reg;
    assign dpos     = dpos_reg;
    assign dt       = dt_reg;
    assign subst    = subst_reg;

endmodule

`default_nettype wire

>>> hw/rtl/mavt_muldiv.sv
// ----------------------------------------------------------------------------
// Serial velocity unit
// Radix-4 shift-add multiply by the tick rate, then a one-bit-per-cycle
// restoring divide by the interval, with sign handling and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module mavt_muldiv #(
    parameter int DT_W = mavt_pkg::INTV_W
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire mavt_pkg::md_ctrl_t           ctrl,
    input  wire logic [mavt_pkg::POS_W-1:0]   dpos,
    input  wire logic [DT_W-1:0]              dt,
    input  wire logic [mavt_pkg::RATE_W-1:0]  rate,
    input  wire logic                         reverse,
    output logic                              done,
    output logic [mavt_pkg::VEL_W-1:0]        velocity
);

    localparam int MAG_W  = mavt_pkg::MAG_W;
    localparam int PROD_W = mavt_pkg::PROD_W;
    localparam int VEL_W  = mavt_pkg::VEL_W;
    localparam int RATE_W = mavt_pkg::RATE_W;
    localparam int DIG_W  = mavt_pkg::MUL_DIGIT_W;
    localparam int CNT_W  = mavt_pkg::CNT_W;
    localparam int HI_W   = PROD_W - VEL_W;

    localparam logic [VEL_W-1:0] VEL_NEG_LIM = {1'b1, {(VEL_W-1){1'b0}}};
    localparam logic [VEL_W-1:0] VEL_POS_LIM = {1'b0, {(VEL_W-1){1'b1}}};

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_PREP = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_DCHK = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_FIN  = 7'b0100000,
        ST_DONE = 7'b1000000
    } md_state_t;

    md_state_t             state_reg;
    md_state_t             state_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;

    logic                  neg_reg;
    logic [MAG_W-1:0]      mag_reg;
    logic [MAG_W+1:0]      mag3_reg;
    logic [RATE_W-1:0]     rate_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic                  ovf_reg;
    logic [DT_W-1:0]       rem_reg;
    logic [VEL_W-1:0]      quot_reg;
    logic [VEL_W-1:0]      vel_reg;

    logic [DIG_W-1:0]      digit;
    logic [MAG_W+1:0]      addend;
    logic [HI_W-1:0]       prod_hi;
    logic                  hi_ovf;
    logic [DT_W:0]         rem_sh;
    logic                  rem_ge;
    logic                  nonzero;
    logic                  vel_neg;
    logic [VEL_W-1:0]      neg_mag;
    logic [VEL_W-1:0]      vel_next;

    always_comb
    begin
        digit = rate_reg[RATE_W-1 -: DIG_W];
        unique case (digit)
            2'd0:    addend = '0;
            2'd1:    addend = {2'b00, mag_reg};
            2'd2:    addend = {1'b0, mag_reg, 1'b0};
            2'd3:    addend = mag3_reg;
            default: addend = '0;
        endcase

        // With the top bits already at or above the divisor the quotient
        // cannot fit the velocity field, so the divide is skipped.
        prod_hi = prod_reg[PROD_W-1:VEL_W];
        hi_ovf  = (DT_W'(prod_hi) >= dt);

        rem_sh = {rem_reg, quot_reg[VEL_W-1]};
        rem_ge = (rem_sh >= {1'b0, dt});

        nonzero = ovf_reg || (quot_reg != '0);
        vel_neg = (neg_reg ^ reverse) && nonzero;
        if (vel_neg)
        begin
            neg_mag  = (ovf_reg || (quot_reg > VEL_NEG_LIM)) ? VEL_NEG_LIM : quot_reg;
            vel_next = '0 - neg_mag;
        end
        else
        begin
            neg_mag  = quot_reg;
            vel_next = (ovf_reg || quot_reg[VEL_W-1]) ? VEL_POS_LIM : quot_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_MUL;
                cnt_next   = CNT_W'(mavt_pkg::MUL_STEPS - 1);
            end
            ST_MUL:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DCHK;
                end
            end
            ST_DCHK:
            begin
                cnt_next   = CNT_W'(mavt_pkg::DIV_STEPS - 1);
                state_next = hi_ovf ? ST_FIN : ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (ctrl.take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && ctrl.start)
        begin
            neg_reg  <= dpos[MAG_W-1];
            mag_reg  <= dpos[MAG_W-1] ? (~dpos + 1'b1) : dpos;
            rate_reg <= rate;
            prod_reg <= '0;
        end
        if (state_reg == ST_PREP)
        begin
            mag3_reg <= {2'b00, mag_reg} + {1'b0, mag_reg, 1'b0};
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= (prod_reg << DIG_W) + PROD_W'(addend);
            rate_reg <= rate_reg << DIG_W;
        end
        if (state_reg == ST_DCHK)
        begin
            ovf_reg  <= hi_ovf;
            rem_reg  <= DT_W'(prod_hi);
            quot_reg <= prod_reg[VEL_W-1:0];
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg  <= rem_ge ? DT_W'(rem_sh - {1'b0, dt}) : rem_sh[DT_W-1:0];
            quot_reg <= {quot_reg[VEL_W-2:0], rem_ge};
        end
        if (state_reg == ST_FIN)
        begin
            vel_reg <= vel_next;
        end
    end

    assign done     = (state_reg == ST_DONE);
    assign velocity = vel_reg;

endmodule

`default_nettype wire

>>> bench/tb_multiturn_angle_velocity_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multi-turn angle and velocity tracker testbench
// Feeds encoder angle and timer stamp samples through the valid/ready
// channels, writes the registers between phases, and checks every result
// against an in-bench model of turn counting and velocity scaling.
// ----------------------------------------------------------------------------

module tb_multiturn_angle_velocity_tracker;

    import mavt_pkg::*;

    localparam int ANG_W = ANGLE_BITS_DEF;
    localparam int TRN_W = TURN_BITS_DEF;
    localparam int TMR_W = TIMER_BITS_DEF;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 800;
    localparam int TAIL_CYCLES = 200;
    localparam int SEG_ITEMS   = 215;
    localparam int SEGMENTS    = 6;

    localparam logic [63:0] VEL_POS_MAX = (64'd1 << (VEL_W - 1)) - 64'd1;
    localparam logic [63:0] VEL_NEG_MAG = 64'd1 << (VEL_W - 1);

    typedef struct {
        logic signed [POS_W-1:0] position;
        logic signed [VEL_W-1:0] velocity;
        logic                    substituted;
    } tracker_result_t;

    class tracker_scoreboard;
        cfg_t             regs;
        logic [ANG_W-1:0] last_angle;
        logic [TRN_W-1:0] turns;
        logic [POS_W-1:0] last_position;
        logic [TMR_W-1:0] last_stamp;
        tracker_result_t  pending_results[$];
        int               errors;
        int               checked;
        int               samples;
        int               wraps;
        int               substitutions;

        function new();
            regs.wrap_threshold         = WRAP_THRESHOLD_RST;
            regs.tick_rate_hz           = TICK_RATE_HZ_RST;
            regs.max_interval_ticks     = MAX_INTERVAL_RST;
            regs.default_interval_ticks = DEFAULT_INTERVAL_RST;
            regs.reverse_direction      = REVERSE_RST;
            last_angle    = '0;
            turns         = '0;
            last_position = '0;
            last_stamp    = '0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_WRAP_THRESHOLD:   regs.wrap_threshold         = value[THR_W-1:0];
                REG_TICK_RATE_HZ:     regs.tick_rate_hz           = value[RATE_W-1:0];
                REG_MAX_INTERVAL:     regs.max_interval_ticks     = value[INTV_W-1:0];
                REG_DEFAULT_INTERVAL: regs.default_interval_ticks = value[INTV_W-1:0];
                REG_REVERSE:          regs.reverse_direction      = value[0];
                default: ;
            endcase
        endfunction

        // Works out the result of one accepted sample and queues it.
        function void note_sample(logic [ANG_W-1:0] angle, logic [TMR_W-1:0] stamp);
            logic [ANG_W-1:0] jump;
            logic             upward;
            logic [POS_W-1:0] pos;
            logic [POS_W-1:0] dpos;
            logic [POS_W-1:0] travel;
            logic [TMR_W-1:0] elapsed;
            logic             subst;
            logic             neg;
            logic [63:0]      quot;
            tracker_result_t  r;

            if (angle >= last_angle)
            begin
                jump   = angle - last_angle;
                upward = (jump != 0);
            end
            else
            begin
                jump   = last_angle - angle;
                upward = 1'b0;
            end
            // A large upward jump means the angle went backward through zero.
            if (jump > regs.wrap_threshold)
            begin
                if (upward)
                    turns = turns - 1'b1;
                else
                    turns = turns + 1'b1;
                wraps++;
            end
            last_angle = angle;
            pos = {turns, angle};

            // The timer counts down, so the elapsed count is old minus new.
            elapsed = last_stamp - stamp;
            subst   = (elapsed == 0) || (elapsed > regs.max_interval_ticks);
            if (subst)
                elapsed = regs.default_interval_ticks;
            if (elapsed == 0)
                elapsed = 1;

            dpos   = pos - last_position;
            neg    = dpos[POS_W-1];
            travel = neg ? (~dpos + 1'b1) : dpos;
            quot   = 64'(travel) * 64'(regs.tick_rate_hz) / 64'(elapsed);
            if (regs.reverse_direction)
                neg = !neg;
            if (quot == 0)
                neg = 1'b0;
            if (neg)
            begin
                if (quot > VEL_NEG_MAG)
                    quot = VEL_NEG_MAG;
                quot = -quot;
            end
            else if (quot > VEL_POS_MAX)
            begin
                quot = VEL_POS_MAX;
            end

            last_position = pos;
            last_stamp    = stamp;

            r.position    = pos;
            r.velocity    = quot[VEL_W-1:0];
            r.substituted = subst;
            pending_results.push_back(r);
            samples++;
            if (subst)
                substitutions++;
        endfunction

        function void check_result(logic signed [POS_W-1:0] position,
                                   logic signed [VEL_W-1:0] velocity,
                                   logic substituted);
            tracker_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result transaction with no sample waiting: position %0d, velocity %0d",
                       position, velocity);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (position !== want.position)
            begin
                $error("position mismatch: expected %0d, actual %0d", want.position, position);
                errors++;
            end
            if (velocity !== want.velocity)
            begin
                $error("velocity mismatch: expected %0d, actual %0d", want.velocity, velocity);
                errors++;
            end
            if (substituted !== want.substituted)
            begin
                $error("interval_substituted mismatch: expected %0b, actual %0b",
                       want.substituted, substituted);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    mavt_sample_if sample_ch ();
    mavt_result_if result_ch ();
    mavt_cfg_if    cfg_ch ();

    multiturn_angle_velocity_tracker i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    tracker_scoreboard sb = new();

    int send_idle_pct = 35;
    int recv_idle_pct = 81;
    int holds_asked   = 0;
    int holds_done    = 0;
    int cycle_count   = 0;
    int settings_used = 1;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, sb.pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Results are checked before the sample of the same edge is noted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.position, result_ch.velocity,
                                result_ch.interval_substituted);
            if (sample_ch.valid && sample_ch.ready)
                sb.note_sample(sample_ch.enc_angle, sample_ch.timestamp);
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_register(cfg_ch.index, cfg_ch.data);
        end
    end

    // Result receiver; a requested hold keeps ready low so the block backs up.
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_asked)
            begin
                holds_done++;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic cfg_t make_cfg(logic [THR_W-1:0] thr, logic [RATE_W-1:0] rate,
                                      logic [INTV_W-1:0] max_intv,
                                      logic [INTV_W-1:0] def_intv, logic rev);
        cfg_t c;
        c.wrap_threshold         = thr;
        c.tick_rate_hz           = rate;
        c.max_interval_ticks     = max_intv;
        c.default_interval_ticks = def_intv;
        c.reverse_direction      = rev;
        return c;
    endfunction

    task automatic send_sample(input logic [ANG_W-1:0] angle, input logic [TMR_W-1:0] stamp);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.enc_angle <= angle;
        sample_ch.timestamp <= stamp;
        do @(posedge clk); while (!sample_ch.ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Upper data bits above each register's width are random junk.
    task automatic configure(input cfg_t c);
        write_reg(REG_WRAP_THRESHOLD, {16'($urandom), c.wrap_threshold});
        write_reg(REG_TICK_RATE_HZ, c.tick_rate_hz);
        write_reg(REG_MAX_INTERVAL, {4'($urandom), c.max_interval_ticks});
        write_reg(REG_DEFAULT_INTERVAL, {4'($urandom), c.default_interval_ticks});
        write_reg(REG_REVERSE, {27'($urandom), c.reverse_direction});
        settings_used++;
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        logic [ANG_W-1:0] angle;
        logic [TMR_W-1:0] stamp;
        int               step;
        int               kind;
        cfg_t             c;

        rst_n               = 1'b0;
        sample_ch.valid     = 1'b0;
        sample_ch.enc_angle = '0;
        sample_ch.timestamp = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: equal stamps, counter wrap, jumps at the threshold.
        send_sample(12'd0, 24'h000000);
        send_sample(12'd4095, 24'hFFFFFF);
        send_sample(12'd0, 24'hFFFFFE);
        send_sample(12'd3277, 24'hFFF000);
        send_sample(12'd0, 24'hFFF000);
        send_sample(12'd3278, 24'h000100);
        send_sample(12'd0, 24'h000100);
        send_sample(12'd2048, 24'h000000);
        send_sample(12'd4095, 24'h800000);

        // Every angle change wraps, one tick is the longest interval and a
        // zero default interval stands in as one tick.
        drain();
        configure(make_cfg('0, '1, 24'd1, 24'd0, 1'b1));
        for (int i = int'(REG_REVERSE) + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(i[CFG_IDX_W-1:0], 28'($urandom));
        send_sample(12'd1, 24'h7FFFFF);
        send_sample(12'd1, 24'h7FFFFD);
        send_sample(12'd0, 24'h7FFFFC);
        send_sample(12'd4095, 24'h7FFFFB);
        send_sample(12'd4094, 24'h7FFFFB);

        // No wrap is possible and a zero tick rate gives zero velocity.
        drain();
        configure(make_cfg('1, 28'd0, '1, '1, 1'b0));
        send_sample(12'd4095, 24'h000000);
        send_sample(12'd0, 24'hFFFFFF);
        send_sample(12'd4095, 24'h000001);

        // Slow rate: small quotients truncate to zero and lose their sign.
        drain();
        configure(make_cfg(12'd2048, 28'd1, 24'd1000, '1, 1'b1));
        send_sample(12'd4094, 24'h000000);
        send_sample(12'd4093, 24'hFFFFF0);
        send_sample(12'd2000, 24'hFFFF00);
        send_sample(12'd0, 24'hFFFE00);

        angle = '0;
        stamp = '0;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            drain();
            if (seg < 2)
            begin
                send_idle_pct = 35;
                recv_idle_pct = 81;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 35;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (seg)
                0: c = make_cfg(WRAP_THRESHOLD_RST, TICK_RATE_HZ_RST, MAX_INTERVAL_RST,
                                DEFAULT_INTERVAL_RST, REVERSE_RST);
                1: c = make_cfg('1, '1, '1, '1, 1'b1);
                2: c = make_cfg('0, 28'd1, 24'd1, 24'd1, 1'b0);
                default: c = make_cfg(12'($urandom), 28'($urandom),
                                      24'($urandom_range(1000, 16777215)),
                                      24'($urandom), 1'($urandom));
            endcase
            configure(c);
            if (seg == SEGMENTS - 1)
                holds_asked <= holds_asked + 1;

            repeat (SEG_ITEMS)
            begin
                kind = $urandom_range(99);
                if (kind < 88)
                begin
                    // Mostly smooth motion of a down-counting timer.
                    if ($urandom_range(3) == 0)
                        step = int'($urandom_range(3000)) - 1500;
                    else
                        step = int'($urandom_range(128)) - 64;
                    angle = ANG_W'(int'(angle) + step);
                    if (kind < 80)
                    begin
                        if ($urandom_range(4) == 0)
                            stamp = stamp - TMR_W'($urandom_range(1, 16777215));
                        else
                            stamp = stamp - TMR_W'($urandom_range(1, 300000));
                    end
                end
                else
                begin
                    angle = ANG_W'($urandom);
                    stamp = TMR_W'($urandom);
                end
                send_sample(angle, stamp);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d samples and %0d checked results over %0d settings,",
                 sb.samples, sb.checked, settings_used);
        $display("with %0d revolution wraps and %0d substituted intervals.",
                 sb.wraps, sb.substitutions);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/mavt_pkg.sv
hw/rtl/mavt_if.sv
hw/rtl/mavt_cfg.sv
hw/rtl/mavt_track.sv
hw/rtl/mavt_muldiv.sv
hw/rtl/multiturn_angle_velocity_tracker.sv
bench/tb_multiturn_angle_velocity_tracker.sv
